// ===== rtl/voh_pkg.sv =====
// ----------------------------------------------------------------------------
// voh_pkg: shared types and constants of the voxel occupancy histogram.
// Holds operation codes, register indexes and the queue entry type.
// ----------------------------------------------------------------------------
package voh_pkg;

   localparam logic OP_ADD  = 1'b0;
   localparam logic OP_READ = 1'b1;

   localparam logic [2:0] REG_MIN_X  = 3'd0;
   localparam logic [2:0] REG_MIN_Y  = 3'd1;
   localparam logic [2:0] REG_MIN_Z  = 3'd2;
   localparam logic [2:0] REG_SIZE_X = 3'd3;
   localparam logic [2:0] REG_SIZE_Y = 3'd4;
   localparam logic [2:0] REG_SIZE_Z = 3'd5;

   localparam logic [30:0] SIZE_RESET = 31'd3277;
   localparam int QW = 8;   // stored index bits per axis (covers up to 256 cells)

   // One classified item handed from the front part to the back part.
   typedef struct packed {
      logic          op;
      logic          in_grid;
      logic [QW-1:0] ix;
      logic [QW-1:0] iy;
      logic [QW-1:0] iz;
      logic [31:0]   cx;
      logic [31:0]   cy;
      logic [31:0]   cz;
   } item_type;

   typedef enum logic [1:0] {
      FE_IDLE,
      FE_DIV,
      FE_PUSH
   } fe_state_type;

   typedef enum logic [2:0] {
      BE_CLEAR,
      BE_IDLE,
      BE_READ,
      BE_WAIT,
      BE_WRITE
   } be_state_type;

endpackage

// ===== rtl/voxel_occupancy_histogram.sv =====
// ----------------------------------------------------------------------------
// voxel_occupancy_histogram: 3-D grid of saturating per-voxel hit counters.
// Points are binned by floor division; cells can be read back with centers.
// ----------------------------------------------------------------------------
//
//   channel  handshake            payload
//   -------  -------------------  ---------------------------------------------
//   req      start / busy         req_operation, req_point_*, req_query_cell_*
//   rsp      rsp_valid (strobe)   rsp_in_grid, rsp_hit_count, rsp_occupied,
//                                 rsp_cell_mid_*
//   csr      csr_valid/csr_ready  csr_index, csr_data
//
// An add beat runs the dividers (33 quotient steps) in the front part and a
// read beat computes cell centers; the back part then does the counter
// read-modify-write through the single memory port. The front part takes no
// new beat until it has pushed the last one into the queue. After reset the
// back part clears every counter memory entry, one per cycle; beats queue up
// in the meantime. The result strobe lasts one cycle; the receiver cannot stall.

module voxel_occupancy_histogram #(
   parameter int CELLS_X = 32,
   parameter int CELLS_Y = 32,
   parameter int CELLS_Z = 32
) (
   input  logic        clock,
   input  logic        reset,
   input  logic        start,
   output logic        busy,
   input  logic        req_operation,
   input  logic [31:0] req_point_x,
   input  logic [31:0] req_point_y,
   input  logic [31:0] req_point_z,
   input  logic [4:0]  req_query_cell_x,
   input  logic [4:0]  req_query_cell_y,
   input  logic [4:0]  req_query_cell_z,
   output logic        rsp_valid,
   output logic        rsp_in_grid,
   output logic [31:0] rsp_hit_count,
   output logic        rsp_occupied,
   output logic [31:0] rsp_cell_mid_x,
   output logic [31:0] rsp_cell_mid_y,
   output logic [31:0] rsp_cell_mid_z,
   input  logic        csr_valid,
   output logic        csr_ready,
   input  logic [2:0]  csr_index,
   input  logic [31:0] csr_data
);

   // Configuration registers; user changes them only while idle; unenforced.
   logic [31:0] min_x_ff, min_y_ff, min_z_ff;
   logic [30:0] size_x_ff, size_y_ff, size_z_ff;
   logic              q_push, q_full, q_pop, q_empty;
   voh_pkg::item_type q_din, q_dout;

   assign csr_ready = 1'b1;

   always_ff @(posedge clock) begin
      if (reset) begin
         min_x_ff  <= '0;
         min_y_ff  <= '0;
         min_z_ff  <= '0;
         size_x_ff <= voh_pkg::SIZE_RESET;
         size_y_ff <= voh_pkg::SIZE_RESET;
         size_z_ff <= voh_pkg::SIZE_RESET;
      end else if (csr_valid) begin
         unique case (csr_index)
            voh_pkg::REG_MIN_X:  min_x_ff  <= csr_data;
            voh_pkg::REG_MIN_Y:  min_y_ff  <= csr_data;
            voh_pkg::REG_MIN_Z:  min_z_ff  <= csr_data;
            voh_pkg::REG_SIZE_X: size_x_ff <= csr_data[30:0];
            voh_pkg::REG_SIZE_Y: size_y_ff <= csr_data[30:0];
            voh_pkg::REG_SIZE_Z: size_z_ff <= csr_data[30:0];
            default: ;
         endcase
      end
   end

   // Front part: takes beats, runs the dividers or the center math.
   voh_front #(.CELLS_X(CELLS_X), .CELLS_Y(CELLS_Y), .CELLS_Z(CELLS_Z)) u_front (
      .clock, .reset, .start, .busy,
      .op(req_operation), .px(req_point_x), .py(req_point_y), .pz(req_point_z),
      .qx(req_query_cell_x), .qy(req_query_cell_y), .qz(req_query_cell_z),
      .min_x(min_x_ff), .min_y(min_y_ff), .min_z(min_z_ff),
      .size_x(size_x_ff), .size_y(size_y_ff), .size_z(size_z_ff),
      .push(q_push), .item(q_din), .full(q_full)
   );

   // The queue lets the front part finish a beat while the back part clears.
   voh_queue u_queue (
      .clock, .reset, .push(q_push), .din(q_din), .full(q_full),
      .pop(q_pop), .empty(q_empty), .dout(q_dout)
   );

   // Back part: owns the counter memory and the result strobe.
   voh_back #(.CELLS_X(CELLS_X), .CELLS_Y(CELLS_Y), .CELLS_Z(CELLS_Z)) u_back (
      .clock, .reset, .empty(q_empty), .item(q_dout), .pop(q_pop),
      .rsp_valid, .rsp_in_grid, .rsp_hit_count, .rsp_occupied,
      .rsp_cell_mid_x, .rsp_cell_mid_y, .rsp_cell_mid_z
   );

endmodule

// ===== rtl/voh_ram.sv =====
// ----------------------------------------------------------------------------
// voh_ram: generic single-port RAM with registered read.
// One access per cycle; a write cycle also reads the old word.
// ----------------------------------------------------------------------------
module voh_ram #(
   parameter int WIDTH = 32,
   parameter int DEPTH = 32768
) (
   input  logic                     clock,
   input  logic                     we,
   input  logic [$clog2(DEPTH)-1:0] addr,
   input  logic [WIDTH-1:0]         wdata,
   output logic [WIDTH-1:0]         rdata
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rdata_ff;

   always_ff @(posedge clock) begin
      if (we) begin
         mem_ff[addr] <= wdata;
      end
      rdata_ff <= mem_ff[addr];
   end

   assign rdata = rdata_ff;

endmodule

// ===== rtl/voh_div.sv =====
// ----------------------------------------------------------------------------
// voh_div: restoring divider, one quotient bit per cycle while step is high.
// Divides a 33-bit nonnegative offset by a 31-bit size in 33 steps.
// ----------------------------------------------------------------------------
module voh_div (
   input  logic        clock,
   input  logic        load,
   input  logic        step,
   input  logic [32:0] dividend,
   input  logic [30:0] divisor,
   output logic [32:0] quotient
);

   logic [32:0] quo_ff, quo_in;
   logic [31:0] rem_ff, rem_in;
   logic [30:0] dvs_ff;
   logic [32:0] trial;

   always_comb begin
      trial  = {rem_ff, quo_ff[32]} - {2'b00, dvs_ff};
      quo_in = {quo_ff[31:0], ~trial[32]};
      rem_in = trial[32] ? {rem_ff[30:0], quo_ff[32]} : trial[31:0];
   end

   // The quotient holds once the steps are done until the next load.
   always_ff @(posedge clock) begin
      if (load) begin
         quo_ff <= dividend;
         rem_ff <= '0;
         dvs_ff <= divisor;
      end else if (step) begin
         quo_ff <= quo_in;
         rem_ff <= rem_in;
      end
   end

   assign quotient = quo_ff;

endmodule

// ===== rtl/voh_front.sv =====
// ----------------------------------------------------------------------------
// voh_front: accepts items, computes cell indices and cell centers.
// Adds run three dividers; reads compute centers with one multiply per axis.
// ----------------------------------------------------------------------------
module voh_front #(
   parameter int CELLS_X = 32,
   parameter int CELLS_Y = 32,
   parameter int CELLS_Z = 32
) (
   input  logic                clock,
   input  logic                reset,
   input  logic                start,
   output logic                busy,
   input  logic                op,
   input  logic [31:0]         px,
   input  logic [31:0]         py,
   input  logic [31:0]         pz,
   input  logic [4:0]          qx,
   input  logic [4:0]          qy,
   input  logic [4:0]          qz,
   input  logic [31:0]         min_x,
   input  logic [31:0]         min_y,
   input  logic [31:0]         min_z,
   input  logic [30:0]         size_x,
   input  logic [30:0]         size_y,
   input  logic [30:0]         size_z,
   output logic                push,
   output voh_pkg::item_type   item,
   input  logic                full
);

   localparam int CNT_W = 6;
   localparam logic [CNT_W-1:0] DIV_STEPS = CNT_W'(33);

   voh_pkg::fe_state_type state_ff, state_in;
   logic [CNT_W-1:0] cnt_ff, cnt_in;
   logic             op_ff, neg_ff;
   logic [4:0]       qx_ff, qy_ff, qz_ff;
   logic [32:0]      dx, dy, dz;
   logic [32:0]      quo_x, quo_y, quo_z;
   logic             accept, load, step;
   logic             in_x, in_y, in_z;
   logic [31:0]      cx, cy, cz;

   assign accept = start && !busy;
   assign load   = accept;
   assign step   = (state_ff == voh_pkg::FE_DIV);

   assign dx = {px[31], px} - {min_x[31], min_x};
   assign dy = {py[31], py} - {min_y[31], min_y};
   assign dz = {pz[31], pz} - {min_z[31], min_z};

   voh_div u_div_x (.clock, .load, .step, .dividend(dx), .divisor(size_x), .quotient(quo_x));
   voh_div u_div_y (.clock, .load, .step, .dividend(dy), .divisor(size_y), .quotient(quo_y));
   voh_div u_div_z (.clock, .load, .step, .dividend(dz), .divisor(size_z), .quotient(quo_z));

   // Center: min + idx*size + size/2, saturated to 32 signed bits.
   function automatic logic [31:0] centre(input logic [4:0] idx, input logic [31:0] lo,
                                          input logic [30:0] sz);
      logic signed [38:0] c;
      begin
         c = 39'(signed'(lo)) + signed'({3'b000, 36'(idx * sz)})
             + signed'({9'd0, sz[30:1]});
         if (c > 39'sh7FFFFFFF) begin
            centre = 32'h7FFFFFFF;
         end else if (c < -39'sh80000000) begin
            centre = 32'h80000000;
         end else begin
            centre = c[31:0];
         end
      end
   endfunction

   assign cx = centre(qx_ff, min_x, size_x);
   assign cy = centre(qy_ff, min_y, size_y);
   assign cz = centre(qz_ff, min_z, size_z);

   assign in_x = (size_x != '0) && (quo_x < 33'(CELLS_X));
   assign in_y = (size_y != '0) && (quo_y < 33'(CELLS_Y));
   assign in_z = (size_z != '0) && (quo_z < 33'(CELLS_Z));

   always_ff @(posedge clock) begin
      if (accept) begin
         op_ff  <= op;
         neg_ff <= dx[32] | dy[32] | dz[32];
         qx_ff  <= qx;
         qy_ff  <= qy;
         qz_ff  <= qz;
      end
   end

   always_comb begin
      state_in = state_ff;
      cnt_in   = cnt_ff;
      unique case (state_ff)
         voh_pkg::FE_IDLE: begin
            if (accept) begin
               state_in = (op == voh_pkg::OP_ADD) ? voh_pkg::FE_DIV : voh_pkg::FE_PUSH;
               cnt_in   = '0;
            end
         end
         voh_pkg::FE_DIV: begin
            cnt_in = cnt_ff + CNT_W'(1);
            if (cnt_ff == DIV_STEPS - CNT_W'(1)) begin
               state_in = voh_pkg::FE_PUSH;
            end
         end
         voh_pkg::FE_PUSH: begin
            if (!full) begin
               state_in = voh_pkg::FE_IDLE;
            end
         end
         default: state_in = voh_pkg::FE_IDLE;
      endcase
   end

   always_comb begin
      busy = (state_ff != voh_pkg::FE_IDLE);
      push = (state_ff == voh_pkg::FE_PUSH) && !full;
      item.op = op_ff;
      if (op_ff == voh_pkg::OP_ADD) begin
         item.in_grid = !neg_ff && in_x && in_y && in_z;
         item.ix = quo_x[voh_pkg::QW-1:0];
         item.iy = quo_y[voh_pkg::QW-1:0];
         item.iz = quo_z[voh_pkg::QW-1:0];
         item.cx = '0;
         item.cy = '0;
         item.cz = '0;
      end else begin
         item.in_grid = (32'(qx_ff) < 32'(CELLS_X)) && (32'(qy_ff) < 32'(CELLS_Y))
                        && (32'(qz_ff) < 32'(CELLS_Z));
         item.ix = voh_pkg::QW'(qx_ff);
         item.iy = voh_pkg::QW'(qy_ff);
         item.iz = voh_pkg::QW'(qz_ff);
         item.cx = cx;
         item.cy = cy;
         item.cz = cz;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= voh_pkg::FE_IDLE;
         cnt_ff   <= '0;
      end else begin
         state_ff <= state_in;
         cnt_ff   <= cnt_in;
      end
   end

endmodule

// ===== rtl/voh_queue.sv =====
// ----------------------------------------------------------------------------
// voh_queue: two-entry queue of classified items between front and back.
// ----------------------------------------------------------------------------
module voh_queue (
   input  logic              clock,
   input  logic              reset,
   input  logic              push,
   input  voh_pkg::item_type din,
   output logic              full,
   input  logic              pop,
   output logic              empty,
   output voh_pkg::item_type dout
);

   voh_pkg::item_type slot_ff [2];
   logic       wp_ff, wp_in, rp_ff, rp_in;
   logic [1:0] cnt_ff, cnt_in;

   assign full  = (cnt_ff == 2'd2);
   assign empty = (cnt_ff == 2'd0);
   assign dout  = slot_ff[rp_ff];

   always_comb begin
      wp_in  = wp_ff ^ push;
      rp_in  = rp_ff ^ pop;
      cnt_in = cnt_ff + 2'(push) - 2'(pop);
   end

   always_ff @(posedge clock) begin
      if (push) begin
         slot_ff[wp_ff] <= din;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wp_ff  <= 1'b0;
         rp_ff  <= 1'b0;
         cnt_ff <= '0;
      end else begin
         wp_ff  <= wp_in;
         rp_ff  <= rp_in;
         cnt_ff <= cnt_in;
      end
   end

endmodule

// ===== rtl/voh_back.sv =====
// ----------------------------------------------------------------------------
// voh_back: clears the counter memory after reset, then reads or
// increments one counter per item and drives the result strobe.
// ----------------------------------------------------------------------------
module voh_back #(
   parameter int CELLS_X = 32,
   parameter int CELLS_Y = 32,
   parameter int CELLS_Z = 32
) (
   input  logic              clock,
   input  logic              reset,
   input  logic              empty,
   input  voh_pkg::item_type item,
   output logic              pop,
   output logic              rsp_valid,
   output logic              rsp_in_grid,
   output logic [31:0]       rsp_hit_count,
   output logic              rsp_occupied,
   output logic [31:0]       rsp_cell_mid_x,
   output logic [31:0]       rsp_cell_mid_y,
   output logic [31:0]       rsp_cell_mid_z
);

   localparam int CELLS = CELLS_X * CELLS_Y * CELLS_Z;
   localparam int AW    = (CELLS > 1) ? $clog2(CELLS) : 1;
   localparam int DEPTH = 1 << AW;

   voh_pkg::be_state_type state_ff, state_in;
   logic [AW:0]     clr_ff, clr_in;
   voh_pkg::item_type cur_ff;
   logic [AW-1:0]   addr, cell_addr;
   logic            we;
   logic [31:0]     wdata, rdata, incr;
   logic            vld_ff, vld_in, ing_ff, ing_in, occ_ff, occ_in;
   logic [31:0]     cnt_ff, cnt_in, cxo_ff, cyo_ff, czo_ff;

   assign cell_addr = AW'((32'(cur_ff.ix) * 32'(CELLS_Y) + 32'(cur_ff.iy)) * 32'(CELLS_Z)
                          + 32'(cur_ff.iz));
   assign incr = (rdata == 32'hFFFFFFFF) ? rdata : rdata + 32'd1;

   voh_ram #(.WIDTH(32), .DEPTH(DEPTH)) u_ram (
      .clock, .we, .addr, .wdata, .rdata
   );

   always_comb begin
      state_in = state_ff;
      clr_in   = clr_ff;
      unique case (state_ff)
         voh_pkg::BE_CLEAR: begin
            clr_in = clr_ff + (AW+1)'(1);
            if (clr_ff == (AW+1)'(DEPTH - 1)) begin
               state_in = voh_pkg::BE_IDLE;
            end
         end
         voh_pkg::BE_IDLE:  if (!empty) state_in = voh_pkg::BE_READ;
         voh_pkg::BE_READ:  state_in = voh_pkg::BE_WAIT;
         voh_pkg::BE_WAIT:  state_in = voh_pkg::BE_WRITE;
         voh_pkg::BE_WRITE: state_in = voh_pkg::BE_IDLE;
         default:           state_in = voh_pkg::BE_IDLE;
      endcase
   end

   always_comb begin
      pop    = (state_ff == voh_pkg::BE_IDLE) && !empty;
      we     = 1'b0;
      addr   = cell_addr;
      wdata  = incr;
      vld_in = 1'b0;
      ing_in = 1'b0;
      cnt_in = '0;
      occ_in = 1'b0;
      unique case (state_ff)
         voh_pkg::BE_CLEAR: begin
            we    = 1'b1;
            addr  = clr_ff[AW-1:0];
            wdata = '0;
         end
         voh_pkg::BE_WRITE: begin
            we     = cur_ff.in_grid && (cur_ff.op == voh_pkg::OP_ADD);
            vld_in = 1'b1;
            ing_in = cur_ff.in_grid;
            if (cur_ff.in_grid) begin
               cnt_in = (cur_ff.op == voh_pkg::OP_ADD) ? incr : rdata;
               occ_in = (cur_ff.op == voh_pkg::OP_ADD) ? 1'b1 : (rdata != '0);
            end
         end
         default: ;
      endcase
   end

   always_ff @(posedge clock) begin
      if (pop) begin
         cur_ff <= item;
      end
      if (state_ff == voh_pkg::BE_WRITE) begin
         cxo_ff <= cur_ff.cx;
         cyo_ff <= cur_ff.cy;
         czo_ff <= cur_ff.cz;
      end
      ing_ff <= ing_in;
      cnt_ff <= cnt_in;
      occ_ff <= occ_in;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= voh_pkg::BE_CLEAR;
         clr_ff   <= '0;
         vld_ff   <= 1'b0;
      end else begin
         state_ff <= state_in;
         clr_ff   <= clr_in;
         vld_ff   <= vld_in;
      end
   end

   assign rsp_valid      = vld_ff;
   assign rsp_in_grid    = ing_ff;
   assign rsp_hit_count  = cnt_ff;
   assign rsp_occupied   = occ_ff;
   assign rsp_cell_mid_x = cxo_ff;
   assign rsp_cell_mid_y = cyo_ff;
   assign rsp_cell_mid_z = czo_ff;

endmodule

// ===== rtl/voh_checker.sv =====
// ----------------------------------------------------------------------------
// voh_checker: port-level checks of the voxel occupancy histogram.
// ----------------------------------------------------------------------------
module voh_checker (
   input logic        clock,
   input logic        reset,
   input logic        start,
   input logic        busy,
   input logic        rsp_valid,
   input logic        rsp_in_grid,
   input logic [31:0] rsp_hit_count,
   input logic        rsp_occupied
);

   // A counted point always leaves a nonzero count.
   assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_in_grid && rsp_occupied |-> rsp_hit_count != '0)
      else $error("occupied cell with zero count");

   // Occupied always implies in grid.
   assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_occupied |-> rsp_in_grid)
      else $error("occupied outside grid");

   // An accepted beat makes the front part busy next cycle.
   assert property (@(posedge clock) disable iff (reset)
      start && !busy |=> busy)
      else $error("busy did not rise after accept");

   // Dropped results carry no count.
   assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_in_grid |-> rsp_hit_count == '0 && !rsp_occupied)
      else $error("dropped result carries a count");

endmodule

bind voxel_occupancy_histogram voh_checker u_voh_checker (
   .clock, .reset, .start, .busy, .rsp_valid, .rsp_in_grid, .rsp_hit_count,
   .rsp_occupied
);
